// ===== hw/rtl/tcpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared constants, codes and controller/datapath handshake types for the
// three-class priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpq_pkg;

  // ring sizing
  localparam int CLASS_DEPTH = 32;
  localparam int NUM_CLASSES = 3;
  localparam int TAG_BITS    = 16;
  localparam int KEY_BITS    = 27;

  // derived widths
  localparam int CLASS_BITS = 2;
  localparam int POS_BITS   = $clog2(CLASS_DEPTH);
  localparam int FILL_BITS  = $clog2(CLASS_DEPTH + 1);
  localparam int ENTRIES    = NUM_CLASSES * CLASS_DEPTH;
  localparam int ADDR_BITS  = $clog2(ENTRIES);
  localparam int COUNT_BITS = $clog2(ENTRIES + 1);
  localparam int ENTRY_BITS = KEY_BITS + TAG_BITS;

  // configuration register indexes
  localparam int REG_INDEX_BITS = 1;
  localparam logic [REG_INDEX_BITS-1:0] REG_LOW_THRESHOLD  = 1'b0;
  localparam logic [REG_INDEX_BITS-1:0] REG_HIGH_THRESHOLD = 1'b1;

  // threshold reset values
  localparam logic [KEY_BITS-1:0] LOW_THRESHOLD_RESET  = KEY_BITS'(40000000);
  localparam logic [KEY_BITS-1:0] HIGH_THRESHOLD_RESET = KEY_BITS'(70000000);

  // request actions
  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  // priority classes
  localparam logic [CLASS_BITS-1:0] CLASS_URGENT = 2'd0;
  localparam logic [CLASS_BITS-1:0] CLASS_MIDDLE = 2'd1;
  localparam logic [CLASS_BITS-1:0] CLASS_LAST   = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD
  } tcpq_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } tcpq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } tcpq_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcpq_ram.sv =====
// ----------------------------------------------------------------------------
// tcpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Sequencer: takes a request, runs one update step, then loads the result
// register once it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire tcpq_pkg::tcpq_status_t status,
  output tcpq_pkg::tcpq_cmd_t        cmd
);

  tcpq_pkg::tcpq_state_t state;
  tcpq_pkg::tcpq_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcpq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tcpq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = tcpq_pkg::ST_EXEC;
        end
      end
      tcpq_pkg::ST_EXEC: begin
        state_next = tcpq_pkg::ST_LOAD;
      end
      tcpq_pkg::ST_LOAD: begin
        if (!status.out_busy) begin
          state_next = tcpq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcpq_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.load    = 1'b0;
    case (state)
      tcpq_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      tcpq_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      tcpq_pkg::ST_LOAD: begin
        cmd.load = !status.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcpq_datapath.sv =====
// ----------------------------------------------------------------------------
// tcpq_datapath
// Thresholds, per-class ring pointers and fill counts, the shared entry
// memory and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [tcpq_pkg::REG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [tcpq_pkg::KEY_BITS-1:0]         cfg_data,
  input  wire logic                                  action,
  input  wire logic [tcpq_pkg::KEY_BITS-1:0]         item_key,
  input  wire logic [tcpq_pkg::TAG_BITS-1:0]         item_tag,
  input  wire tcpq_pkg::tcpq_cmd_t                   cmd,
  output tcpq_pkg::tcpq_status_t                     status,
  input  wire logic                                  out_ready,
  output logic                                       out_valid,
  output logic                                       item_valid,
  output logic      [tcpq_pkg::KEY_BITS-1:0]         out_key,
  output logic      [tcpq_pkg::TAG_BITS-1:0]         out_tag,
  output logic                                       enqueue_accepted,
  output logic      [tcpq_pkg::COUNT_BITS-1:0]       total_count,
  output logic                                       queue_empty
);

  localparam int NC = tcpq_pkg::NUM_CLASSES;

  logic [tcpq_pkg::KEY_BITS-1:0]   low_threshold;
  logic [tcpq_pkg::KEY_BITS-1:0]   high_threshold;

  // captured request
  logic                            act_q;
  logic [tcpq_pkg::KEY_BITS-1:0]   key_q;
  logic [tcpq_pkg::TAG_BITS-1:0]   tag_q;

  // ring state
  logic [tcpq_pkg::POS_BITS-1:0]   head  [NC];
  logic [tcpq_pkg::POS_BITS-1:0]   tail  [NC];
  logic [tcpq_pkg::FILL_BITS-1:0]  fill  [NC];
  logic [tcpq_pkg::COUNT_BITS-1:0] total;
  logic [tcpq_pkg::COUNT_BITS-1:0] total_next;

  // pending result
  logic                            res_item_valid;
  logic                            res_accepted;
  logic [tcpq_pkg::COUNT_BITS-1:0] res_total;

  logic [NC-1:0]                   full_vec;
  logic [NC-1:0]                   nonempty;
  logic [tcpq_pkg::CLASS_BITS-1:0] enq_cls;
  logic [tcpq_pkg::CLASS_BITS-1:0] deq_cls;
  logic [tcpq_pkg::CLASS_BITS-1:0] sel_cls;
  logic [tcpq_pkg::POS_BITS-1:0]   sel_pos;
  logic [tcpq_pkg::ADDR_BITS-1:0]  slot;
  logic                            is_deq;
  logic                            enq_ok;
  logic                            deq_ok;
  logic [tcpq_pkg::ENTRY_BITS-1:0] rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold  <= tcpq_pkg::LOW_THRESHOLD_RESET;
      high_threshold <= tcpq_pkg::HIGH_THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        tcpq_pkg::REG_LOW_THRESHOLD:  low_threshold  <= cfg_data;
        tcpq_pkg::REG_HIGH_THRESHOLD: high_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q <= action;
      key_q <= item_key;
      tag_q <= item_tag;
    end
  end

  // class selection on enqueue
  always_comb begin
    if (key_q < low_threshold) begin
      enq_cls = tcpq_pkg::CLASS_URGENT;
    end else if (key_q < high_threshold) begin
      enq_cls = tcpq_pkg::CLASS_MIDDLE;
    end else begin
      enq_cls = tcpq_pkg::CLASS_LAST;
    end
  end

  // per-class full and nonempty flags
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      full_vec[k] = (fill[k] == tcpq_pkg::FILL_BITS'(tcpq_pkg::CLASS_DEPTH));
      nonempty[k] = (fill[k] != '0);
    end
  end

  // highest nonempty class on dequeue
  always_comb begin
    if (nonempty[0]) begin
      deq_cls = tcpq_pkg::CLASS_URGENT;
    end else if (nonempty[1]) begin
      deq_cls = tcpq_pkg::CLASS_MIDDLE;
    end else begin
      deq_cls = tcpq_pkg::CLASS_LAST;
    end
  end

  assign is_deq  = (act_q == tcpq_pkg::ACT_DEQUEUE);
  assign enq_ok  = !is_deq && !full_vec[enq_cls];
  assign deq_ok  = is_deq && (|nonempty);
  assign sel_cls = is_deq ? deq_cls : enq_cls;
  assign sel_pos = is_deq ? head[sel_cls] : tail[sel_cls];
  assign slot    = tcpq_pkg::ADDR_BITS'(sel_cls) *
                   tcpq_pkg::ADDR_BITS'(tcpq_pkg::CLASS_DEPTH) +
                   tcpq_pkg::ADDR_BITS'(sel_pos);

  // item count after this step
  always_comb begin
    total_next = total;
    if (cmd.exec && enq_ok) begin
      total_next = total + 1'b1;
    end else if (cmd.exec && deq_ok) begin
      total_next = total - 1'b1;
    end
  end

  // ring pointers and fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NC; k++) begin
        head[k] <= '0;
        tail[k] <= '0;
        fill[k] <= '0;
      end
      total <= '0;
    end else begin
      total <= total_next;
      for (int k = 0; k < NC; k++) begin
        if (cmd.exec && enq_ok && enq_cls == tcpq_pkg::CLASS_BITS'(k)) begin
          tail[k] <= (tail[k] == tcpq_pkg::POS_BITS'(tcpq_pkg::CLASS_DEPTH - 1)) ?
                     '0 : tail[k] + 1'b1;
          fill[k] <= fill[k] + 1'b1;
        end
        if (cmd.exec && deq_ok && deq_cls == tcpq_pkg::CLASS_BITS'(k)) begin
          head[k] <= (head[k] == tcpq_pkg::POS_BITS'(tcpq_pkg::CLASS_DEPTH - 1)) ?
                     '0 : head[k] + 1'b1;
          fill[k] <= fill[k] - 1'b1;
        end
      end
    end
  end

  // result of the step, waiting for the output register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_item_valid <= deq_ok;
      res_accepted   <= enq_ok;
      res_total      <= total_next;
    end
  end

  // entry memory, key above tag
  tcpq_ram #(
    .WIDTH (tcpq_pkg::ENTRY_BITS),
    .DEPTH (tcpq_pkg::ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.exec && enq_ok),
    .waddr (slot),
    .wdata ({key_q, tag_q}),
    .re    (cmd.exec && deq_ok),
    .raddr (slot),
    .rdata (rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_valid       <= res_item_valid;
      out_key          <= res_item_valid ?
                          rdata[tcpq_pkg::ENTRY_BITS-1:tcpq_pkg::TAG_BITS] : '0;
      out_tag          <= res_item_valid ? rdata[tcpq_pkg::TAG_BITS-1:0] : '0;
      enqueue_accepted <= res_accepted;
      total_count      <= res_total;
      queue_empty      <= (res_total == '0);
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/three_class_priority_queue.sv =====
// ----------------------------------------------------------------------------
// three_class_priority_queue
// Three-class FIFO priority queue: enqueue sorts by key thresholds, dequeue
// returns the head of the most urgent nonempty class.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. The accepting edge captures the
// request; the class ring is then updated and the shared entry memory
// accessed, and the result register, whose memory read is registered, is
// loaded after that once it is free of a result still waiting for out_ready.
// The next request is taken the cycle after the result register is loaded,
// even while that result still waits for out_ready. The entry memory holds
// 3 x 32 entries and needs no clearing pass after reset; only occupied slots
// are ever read. Threshold writes are to be made only while the queue is idle.
`default_nettype none

module three_class_priority_queue (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [tcpq_pkg::REG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [tcpq_pkg::KEY_BITS-1:0]       cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                action,
  input  wire logic [tcpq_pkg::KEY_BITS-1:0]       item_key,
  input  wire logic [tcpq_pkg::TAG_BITS-1:0]       item_tag,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     item_valid,
  output logic      [tcpq_pkg::KEY_BITS-1:0]       out_key,
  output logic      [tcpq_pkg::TAG_BITS-1:0]       out_tag,
  output logic                                     enqueue_accepted,
  output logic      [tcpq_pkg::COUNT_BITS-1:0]     total_count,
  output logic                                     queue_empty
);

  tcpq_pkg::tcpq_cmd_t    cmd;
  tcpq_pkg::tcpq_status_t status;

  // sequencer
  tcpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // rings, memory and result register
  tcpq_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .action           (action),
    .item_key         (item_key),
    .item_tag         (item_tag),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .item_valid       (item_valid),
    .out_key          (out_key),
    .out_tag          (out_tag),
    .enqueue_accepted (enqueue_accepted),
    .total_count      (total_count),
    .queue_empty      (queue_empty)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/tcpq_checker.sv =====
// ----------------------------------------------------------------------------
// tcpq_checker
// Port-level checks on the result channel of the priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic                                item_valid,
  input wire logic [tcpq_pkg::KEY_BITS-1:0]       out_key,
  input wire logic [tcpq_pkg::TAG_BITS-1:0]       out_tag,
  input wire logic                                enqueue_accepted,
  input wire logic [tcpq_pkg::COUNT_BITS-1:0]     total_count,
  input wire logic                                queue_empty
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_tag)
      && $stable(total_count))
    else $error("result changed while stalled");

  // a dequeued item never reports an enqueue
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_valid |-> !enqueue_accepted)
    else $error("item and enqueue flags both set");

  // empty flag follows the count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (queue_empty == (total_count == '0)))
    else $error("empty flag disagrees with count");

  // count bounded by total ring capacity
  a_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> total_count <= tcpq_pkg::COUNT_BITS'(tcpq_pkg::ENTRIES))
    else $error("count above capacity");

  // no item means zero payload
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !item_valid |-> out_key == '0 && out_tag == '0)
    else $error("payload set without item");

endmodule

bind three_class_priority_queue tcpq_checker u_tcpq_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .item_valid       (item_valid),
  .out_key          (out_key),
  .out_tag          (out_tag),
  .enqueue_accepted (enqueue_accepted),
  .total_count      (total_count),
  .queue_empty      (queue_empty)
);

`default_nettype wire
